/* sv/lfp_pkg.sv */
`default_nettype none
package lfp_pkg;

    localparam int unsigned HeaderBytes = 9;
    localparam logic [7:0]  MarkerReset = 8'd94;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_START = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [3:0] POS_ID_FIRST = 4'd1;
    localparam logic [3:0] POS_ID_LAST  = 4'd4;
    localparam logic [3:0] POS_VERSION  = 4'd5;
    localparam logic [3:0] POS_TYPE     = 4'd6;
    localparam logic [3:0] POS_LEN_LAST = 4'(HeaderBytes - 1);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HEAD = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] peer_id;
        logic [7:0]  version;
        logic [3:0]  class_hi;
        logic [3:0]  class_lo;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* sv/length_prefixed_frame_parser_core.sv */
// output: a result is registered, appearing in the cycle after the byte transfer that causes it
// throughput: one byte per cycle unless o_stall; the output takes a new result as the old one leaves
// a matching marker or non-final header byte gives no result unless the buffer ends; at most one per byte
// reset (synchronous, active low): parser back to hunting, output empty, marker to 94
`default_nettype none
module length_prefixed_frame_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_buffer_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [31:0]      o_peer_id,
    output logic [7:0]       o_version,
    output logic [3:0]       o_class_hi,
    output logic [3:0]       o_class_lo,
    output logic [15:0]      o_payload_length,
    output logic [7:0]       o_payload_byte,
    output logic             o_last
);

    logic [7:0]       r_marker;
    logic             r_out_valid, n_out_valid;
    lfp_pkg::t_result r_out;
    lfp_pkg::t_result res;
    logic             res_valid;
    logic             accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    lfp_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .i_marker     (r_marker),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_comb begin
        if (accept) begin
            n_out_valid = res_valid;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker    <= lfp_pkg::MarkerReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_status         = r_out.status;
    assign o_peer_id        = r_out.peer_id;
    assign o_version        = r_out.version;
    assign o_class_hi       = r_out.class_hi;
    assign o_class_lo       = r_out.class_lo;
    assign o_payload_length = r_out.payload_length;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_last           = r_out.last;

endmodule
`default_nettype wire

/* sv/lfp_fsm.sv */
`default_nettype none
module lfp_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_buffer_end,
    input  wire logic [7:0]       i_marker,
    output logic                  o_res_valid,
    output lfp_pkg::t_result      o_res
);

    lfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_remaining, n_remaining;

    logic        final_byte;
    logic [15:0] full_len;

    assign final_byte = (r_remaining <= 16'd1);
    assign full_len   = {r_len, i_data_byte};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_id        = r_id;
        n_version   = r_version;
        n_type      = r_type;
        n_len       = r_len;
        n_remaining = r_remaining;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            lfp_pkg::PH_HEAD: begin
                if (r_pos >= lfp_pkg::POS_ID_FIRST && r_pos <= lfp_pkg::POS_ID_LAST) begin
                    n_id = {r_id[23:0], i_data_byte};
                end else if (r_pos == lfp_pkg::POS_VERSION) begin
                    n_version = i_data_byte;
                end else if (r_pos == lfp_pkg::POS_TYPE) begin
                    n_type = i_data_byte;
                end else begin
                    n_len = i_data_byte;
                end
                if (r_pos != lfp_pkg::POS_LEN_LAST) begin
                    n_pos = r_pos + 4'd1;
                    if (i_buffer_end) begin
                        o_res_valid = 1'b1;
                        o_res.kind   = lfp_pkg::KIND_ERROR;
                        o_res.status = lfp_pkg::STATUS_TRUNCATED;
                        n_phase = lfp_pkg::PH_HUNT;
                        n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                        n_len = '0; n_remaining = '0;
                    end
                end else if (i_buffer_end && full_len != 16'd0) begin
                    o_res_valid = 1'b1;
                    o_res.kind   = lfp_pkg::KIND_ERROR;
                    o_res.status = lfp_pkg::STATUS_TRUNCATED;
                    n_phase = lfp_pkg::PH_HUNT;
                    n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                    n_len = '0; n_remaining = '0;
                end else begin
                    o_res_valid = 1'b1;
                    o_res.kind           = lfp_pkg::KIND_HEADER;
                    o_res.status         = lfp_pkg::STATUS_OK;
                    o_res.peer_id        = r_id;
                    o_res.version        = r_version;
                    o_res.class_hi       = r_type[7:4];
                    o_res.class_lo       = r_type[3:0];
                    o_res.payload_length = full_len;
                    o_res.last           = (full_len == 16'd0);
                    if (full_len == 16'd0) begin
                        n_phase = lfp_pkg::PH_HUNT;
                        n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                        n_len = '0; n_remaining = '0;
                    end else begin
                        n_phase     = lfp_pkg::PH_BODY;
                        n_pos       = '0;
                        n_remaining = full_len;
                    end
                end
            end
            lfp_pkg::PH_BODY: begin
                o_res_valid = 1'b1;
                if (i_buffer_end && !final_byte) begin
                    o_res.kind   = lfp_pkg::KIND_ERROR;
                    o_res.status = lfp_pkg::STATUS_TRUNCATED;
                    n_phase = lfp_pkg::PH_HUNT;
                    n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                    n_len = '0; n_remaining = '0;
                end else begin
                    o_res.kind         = lfp_pkg::KIND_PAYLOAD;
                    o_res.status       = lfp_pkg::STATUS_OK;
                    o_res.payload_byte = i_data_byte;
                    o_res.last         = final_byte;
                    if (final_byte) begin
                        n_phase = lfp_pkg::PH_HUNT;
                        n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                        n_len = '0; n_remaining = '0;
                    end else begin
                        n_remaining = r_remaining - 16'd1;
                    end
                end
            end
            default: begin
                // hunting, also any stray phase code
                n_phase = lfp_pkg::PH_HUNT;
                n_pos = '0; n_id = '0; n_version = '0; n_type = '0;
                n_len = '0; n_remaining = '0;
                if (i_data_byte != i_marker) begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = lfp_pkg::KIND_ERROR;
                    o_res.status = lfp_pkg::STATUS_BAD_START;
                end else if (i_buffer_end) begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = lfp_pkg::KIND_ERROR;
                    o_res.status = lfp_pkg::STATUS_TRUNCATED;
                end else begin
                    n_phase = lfp_pkg::PH_HEAD;
                    n_pos   = lfp_pkg::POS_ID_FIRST;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lfp_pkg::PH_HUNT;
            r_pos       <= '0;
            r_id        <= '0;
            r_version   <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_remaining <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_id        <= n_id;
            r_version   <= n_version;
            r_type      <= n_type;
            r_len       <= n_len;
            r_remaining <= n_remaining;
        end
    end

endmodule
`default_nettype wire

/* verif/length_prefixed_frame_parser_core_test.sv */
`default_nettype none
module length_prefixed_frame_parser_core_test;

    localparam int QuietLimit = 400;
    localparam int PhaseCount = 5;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_stream_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_buffer_end = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [1:0]  o_status;
    logic [31:0] o_peer_id;
    logic [7:0]  o_version;
    logic [3:0]  o_class_hi;
    logic [3:0]  o_class_lo;
    logic [15:0] o_payload_length;
    logic [7:0]  o_payload_byte;
    logic        o_last;

    // incoming byte stream and results still owed by the parser
    t_stream_item     stream_bytes[$];
    lfp_pkg::t_result parsed_due[$];

    // parser state as predicted
    logic [7:0]      marker_now;
    lfp_pkg::t_phase scan_phase;
    logic [3:0]      hdr_pos;
    logic [31:0]     id_acc;
    logic [7:0]      ver_acc;
    logic [7:0]      type_acc;
    logic [15:0]     len_acc;
    logic [15:0]     body_left;

    logic byte_taken = 1'b0;
    logic result_taken = 1'b0;
    int   send_wait = 0;
    int   stall_left = 0;
    int   send_gap_max = 9;
    int   hold_gap_max = 9;
    int   fault_count = 0;
    int   quiet_cycles = 0;

    length_prefixed_frame_parser_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_buffer_end     (i_buffer_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_peer_id        (o_peer_id),
        .o_version        (o_version),
        .o_class_hi       (o_class_hi),
        .o_class_lo       (o_class_lo),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic void restart_hunt();
        scan_phase = lfp_pkg::PH_HUNT;
        hdr_pos = 4'd0;
        id_acc = 32'd0;
        ver_acc = 8'd0;
        type_acc = 8'd0;
        len_acc = 16'd0;
        body_left = 16'd0;
    endfunction

    function automatic lfp_pkg::t_result abort_frame(input logic [1:0] code);
        lfp_pkg::t_result r;
        r = '0;
        restart_hunt();
        r.kind = lfp_pkg::KIND_ERROR;
        r.status = code;
        return r;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, input logic fin,
                                        output lfp_pkg::t_result r);
        logic [3:0] pos;
        r = '0;
        if (scan_phase == lfp_pkg::PH_HEAD) begin
            pos = hdr_pos;
            if (pos >= lfp_pkg::POS_ID_FIRST && pos <= lfp_pkg::POS_ID_LAST) begin
                id_acc = {id_acc[23:0], b};
            end else if (pos == lfp_pkg::POS_VERSION) begin
                ver_acc = b;
            end else if (pos == lfp_pkg::POS_TYPE) begin
                type_acc = b;
            end else begin
                len_acc = {len_acc[7:0], b};
            end
            pos = pos + 4'd1;
            if (pos < 4'(lfp_pkg::HeaderBytes)) begin
                hdr_pos = pos;
                if (!fin) return 1'b0;
                r = abort_frame(lfp_pkg::STATUS_TRUNCATED);
                return 1'b1;
            end
            if (fin && len_acc != 16'd0) begin
                r = abort_frame(lfp_pkg::STATUS_TRUNCATED);
                return 1'b1;
            end
            r.kind = lfp_pkg::KIND_HEADER;
            r.peer_id = id_acc;
            r.version = ver_acc;
            r.class_hi = type_acc[7:4];
            r.class_lo = type_acc[3:0];
            r.payload_length = len_acc;
            r.last = (len_acc == 16'd0);
            if (len_acc == 16'd0) begin
                restart_hunt();
            end else begin
                body_left = len_acc;
                hdr_pos = 4'd0;
                scan_phase = lfp_pkg::PH_BODY;
            end
            return 1'b1;
        end
        if (scan_phase == lfp_pkg::PH_BODY) begin
            if (fin && body_left > 16'd1) begin
                r = abort_frame(lfp_pkg::STATUS_TRUNCATED);
                return 1'b1;
            end
            r.kind = lfp_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.last = (body_left <= 16'd1);
            if (body_left <= 16'd1) begin
                restart_hunt();
            end else begin
                body_left = body_left - 16'd1;
            end
            return 1'b1;
        end
        if (b != marker_now) begin
            r = abort_frame(lfp_pkg::STATUS_BAD_START);
            return 1'b1;
        end
        if (fin) begin
            r = abort_frame(lfp_pkg::STATUS_TRUNCATED);
            return 1'b1;
        end
        restart_hunt();
        scan_phase = lfp_pkg::PH_HEAD;
        hdr_pos = lfp_pkg::POS_ID_FIRST;
        return 1'b0;
    endfunction

    function automatic string result_text(input lfp_pkg::t_result r);
        return $sformatf({"kind %0d status %0d id %h ver %h hi %h lo %h",
                          " len %h byte %h last %b"},
                         r.kind, r.status, r.peer_id, r.version, r.class_hi,
                         r.class_lo, r.payload_length, r.payload_byte, r.last);
    endfunction

    // monitor: checks each result transfer, predicts each byte transfer
    always @(posedge i_clk) begin
        lfp_pkg::t_result got;
        lfp_pkg::t_result want;
        lfp_pkg::t_result fresh;
        bit               made;
        byte_taken <= i_rst_n && i_valid && (o_stall === 1'b0);
        result_taken <= i_rst_n && (o_valid === 1'b1) && (i_stall === 1'b0);
        if (!i_rst_n) begin
            marker_now = lfp_pkg::MarkerReset;
            restart_hunt();
        end else begin
            if (i_cfg_we) marker_now = i_cfg_data;
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                got.kind = o_kind;
                got.status = o_status;
                got.peer_id = o_peer_id;
                got.version = o_version;
                got.class_hi = o_class_hi;
                got.class_lo = o_class_lo;
                got.payload_length = o_payload_length;
                got.payload_byte = o_payload_byte;
                got.last = o_last;
                if (parsed_due.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected result: %s", result_text(got));
                    fault_count = fault_count + 1;
                end else begin
                    want = parsed_due.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.peer_id !== want.peer_id || got.version !== want.version ||
                        got.class_hi !== want.class_hi ||
                        got.class_lo !== want.class_lo ||
                        got.payload_length !== want.payload_length ||
                        got.payload_byte !== want.payload_byte || got.last !== want.last)
                    begin
                        if (fault_count < 10)
                            $display("result wrong\n  expected %s\n  actual   %s",
                                     result_text(want), result_text(got));
                        fault_count = fault_count + 1;
                    end
                end
            end
            if (i_valid && o_stall === 1'b0) begin
                made = deframe_byte(i_data_byte, i_buffer_end, fresh);
                if (made) parsed_due.push_back(fresh);
            end
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        t_stream_item nxt;
        if (i_rst_n) begin
            if (!i_valid || byte_taken) begin
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    i_valid <= 1'b0;
                end else if (stream_bytes.size() > 0) begin
                    nxt = stream_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_buffer_end <= nxt.fin;
                    send_wait = int'($urandom_range(0, send_gap_max));
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (result_taken) stall_left = int'($urandom_range(0, hold_gap_max));
        if (o_valid === 1'b1 && stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        t_stream_item it;
        it.data = b;
        it.fin = fin;
        stream_bytes.push_back(it);
    endtask

    // header plus body_count payload bytes; buffer end set on byte stop_at, which ends the frame
    task automatic push_frame(input logic [7:0] mk, input logic [31:0] id,
                              input logic [7:0] ver, input logic [7:0] typ,
                              input logic [15:0] len, input int body_count, input int stop_at);
        logic [71:0] head;
        logic [7:0]  b;
        int          i;
        int          hdr;
        hdr = int'(lfp_pkg::HeaderBytes);
        head = {mk, id, ver, typ, len};
        for (i = 0; i < hdr + body_count; i++) begin
            if (i < hdr)
                b = head[8 * (hdr - 1 - i) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            push_byte(b, i == stop_at);
            if (i == stop_at) break;
        end
    endtask

    task automatic drain_results();
        while (stream_bytes.size() != 0 || i_valid || parsed_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_marker(input logic [7:0] mk);
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= mk;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input logic [7:0] mk, input int budget);
        int          sent;
        int          pick;
        int          body;
        int          total;
        int          stop;
        int          n;
        int          i;
        logic [15:0] len;
        sent = 0;
        while (sent < budget) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 75) begin
                pick = int'($urandom_range(0, 19));
                if (pick < 16)
                    len = 16'($urandom_range(0, 8));
                else if (pick < 19)
                    len = 16'($urandom_range(9, 40));
                else if ($urandom_range(0, 1) == 1)
                    len = 16'hFFFF;
                else
                    len = 16'($urandom_range(41, 65535));
                body = (len > 16'd40) ? int'($urandom_range(0, 12)) : int'(len);
                total = int'(lfp_pkg::HeaderBytes) + body;
                pick = int'($urandom_range(0, 9));
                if (len > 16'd40)
                    stop = int'($urandom_range(1, total - 1));
                else if (pick < 2)
                    stop = int'($urandom_range(0, total - 1));
                else if (pick < 4)
                    stop = total - 1;
                else
                    stop = -1;
                push_frame(mk, $urandom, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), len, body, stop);
                sent = sent + ((stop < 0) ? total : stop + 1);
            end else begin
                n = int'($urandom_range(1, 4));
                for (i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)),
                              (i == n - 1) && ($urandom_range(0, 1) == 1));
                sent = sent + n;
            end
        end
    endtask

    initial begin
        logic [7:0] marker_plan [PhaseCount];
        int         send_plan [PhaseCount];
        int         hold_plan [PhaseCount];
        int         p;
        marker_plan[0] = 8'h00;
        marker_plan[1] = 8'hFF;
        marker_plan[2] = 8'($urandom_range(1, 254));
        marker_plan[3] = lfp_pkg::MarkerReset;
        marker_plan[4] = 8'($urandom_range(0, 255));
        send_plan[0] = 9; hold_plan[0] = 9;
        send_plan[1] = 0; hold_plan[1] = 0;
        send_plan[2] = 9; hold_plan[2] = 0;
        send_plan[3] = 0; hold_plan[3] = 9;
        send_plan[4] = 9; hold_plan[4] = 9;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bad starts, lone marker at buffer end, all-ones empty frame, one-byte frame
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(lfp_pkg::MarkerReset, 1'b1);
        push_frame(lfp_pkg::MarkerReset, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'd0, 0,
                   int'(lfp_pkg::HeaderBytes) - 1);
        push_frame(lfp_pkg::MarkerReset, 32'h0000_0000, 8'h00, 8'hA5, 16'd1, 1,
                   int'(lfp_pkg::HeaderBytes));

        for (p = 0; p < PhaseCount; p++) begin
            set_marker(marker_plan[p]);
            send_gap_max = send_plan[p];
            hold_gap_max = hold_plan[p];
            random_traffic(marker_plan[p], 135);
            drain_results();
            random_traffic(marker_plan[p], 135);
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

/* length_prefixed_frame_parser_core.f */
sv/lfp_pkg.sv
sv/lfp_fsm.sv
sv/length_prefixed_frame_parser_core.sv
verif/length_prefixed_frame_parser_core_test.sv
